// ===== rtl/dvrt_pkg.sv =====
// Types and constants shared by the route table modules.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package dvrt_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

	localparam logic [15:0] OWN_ID_RESET   = 16'd1;
	localparam logic [15:0] RESERVED_RESET = 16'd16;
	localparam logic [31:0] TIMEOUT_RESET  = 32'd30000;

	// Command codes.
	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_AGE    = 3'd1;
	localparam logic [2:0] CMD_IFDROP = 3'd2;
	localparam logic [2:0] CMD_ALLOC  = 3'd3;
	localparam logic [2:0] CMD_LOOKUP = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_CHANGE = 3'd1;
	localparam logic [2:0] ST_OWN_ID    = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [15:0] own_device_id;
		logic [15:0] reserved_id_count;
		logic [31:0] entry_timeout;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] node_addr;
		logic [7:0]  link_id;
		logic [7:0]  distance;
		logic [31:0] time_now;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [7:0]  route_distance;
		logic [7:0]  route_interface;
		logic [15:0] new_device_id;
		logic [5:0]  removed_count;
		logic [5:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] device;
		logic [7:0]  distance;
		logic [7:0]  link_id;
		logic [31:0] seen_time;
	} entry_t;

endpackage

// ===== rtl/dvrt_if.sv =====
// Request and response channel interfaces of the route table.
// Depends on dvrt_pkg for the payload types.
`timescale 1ns / 1ps

interface dvrt_req_if;
	logic          valid;
	logic          ready;
	dvrt_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dvrt_rsp_if;
	logic          valid;
	logic          ready;
	dvrt_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dvrt_mem.sv =====
// Route entry storage: one write port and one registered read port.
// Depends on dvrt_pkg for the entry layout.
`timescale 1ns / 1ps

module dvrt_mem #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  dvrt_pkg::entry_t         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output dvrt_pkg::entry_t         rd_data
);
	import dvrt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/dvrt_ctrl.sv =====
// Request sequencer: table scans, compaction sweeps, id allocation and the
// response register. Depends on dvrt_pkg, dvrt_if and an external dvrt_mem.
`timescale 1ns / 1ps

module dvrt_ctrl #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dvrt_pkg::cfg_t                 cfg,
	dvrt_req_if.sink                       req,
	dvrt_rsp_if.source                     rsp,
	output logic                           mem_wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
	output dvrt_pkg::entry_t               mem_wr_data,
	output logic                           mem_rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
	input  dvrt_pkg::entry_t               mem_rd_data
);
	import dvrt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWEEP, S_EMIT} state_t;

	state_t        state_q;
	req_t          req_q;
	logic [2:0]    st_q;
	logic          found_q;
	logic [7:0]    rdist_q;
	logic [7:0]    rif_q;
	logic [15:0]   newid_q;
	rsp_t          out_q;
	logic          out_valid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] rem_q;
	logic [15:0]   next_cand_q;
	logic [15:0]   cand_q;
	logic [15:0]   start_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;

	logic [15:0] lowest_c;
	logic [15:0] start_c;
	logic [15:0] next_c;
	logic [15:0] key_c;
	logic [31:0] age_c;
	logic        drop_c;
	logic        hit_c;
	logic        done_c;
	logic        issue_c;
	logic        upd_take_c;
	logic        emit_c;
	logic [2:0]  first_st_c;
	entry_t      upd_entry_c;
	entry_t      new_entry_c;
	rsp_t        emit_data_c;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// A reserved count of zero acts as one so that id zero is never handed out.
	assign lowest_c = (cfg.reserved_id_count == 16'd0) ? 16'd1 : cfg.reserved_id_count;
	assign start_c  = (next_cand_q < lowest_c) ? lowest_c : next_cand_q;
	assign next_c   = (cand_q == 16'hFFFF) ? lowest_c : cand_q + 16'd1;
	assign key_c    = (req_q.command == CMD_ALLOC) ? cand_q : req_q.node_addr;

	assign first_st_c = (req.data.command == CMD_UPDATE &&
	                     req.data.node_addr == cfg.own_device_id) ? ST_OWN_ID : ST_NO_CHANGE;

	assign age_c  = req_q.time_now - mem_rd_data.seen_time;
	assign drop_c = (req_q.command == CMD_AGE) ? (age_c > cfg.entry_timeout)
	                                            : (mem_rd_data.link_id == req_q.link_id);

	// Read data arrives in the cycle after the address; pend_s1 marks it as live.
	assign hit_c   = (state_q == S_SCAN) && pend_s1 && (mem_rd_data.device == key_c);
	assign done_c  = !pend_s1 && (rd_ptr_q >= count_q);
	assign issue_c = (((state_q == S_SCAN) && !hit_c) || (state_q == S_SWEEP))
	                 && (rd_ptr_q < count_q);

	assign upd_take_c = (mem_rd_data.distance >= req_q.distance);

	// The response register loads when it is empty or being drained this cycle.
	assign emit_c = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	always_comb begin
		upd_entry_c           = mem_rd_data;
		upd_entry_c.distance  = req_q.distance;
		upd_entry_c.seen_time = req_q.time_now;
		if (mem_rd_data.distance != req_q.distance) begin
			upd_entry_c.link_id = req_q.link_id;
		end
		new_entry_c.device    = req_q.node_addr;
		new_entry_c.distance  = req_q.distance;
		new_entry_c.link_id   = req_q.link_id;
		new_entry_c.seen_time = req_q.time_now;
	end

	always_comb begin
		emit_data_c.status          = st_q;
		emit_data_c.found           = found_q;
		emit_data_c.route_distance  = rdist_q;
		emit_data_c.route_interface = rif_q;
		emit_data_c.new_device_id   = newid_q;
		emit_data_c.removed_count   = 6'(rem_q);
		emit_data_c.entry_count     = 6'(count_q);
	end

	assign mem_rd_en   = issue_c;
	assign mem_rd_addr = rd_ptr_q[AW-1:0];

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_s1;
		mem_wr_data = upd_entry_c;
		if (state_q == S_SCAN && req_q.command == CMD_UPDATE) begin
			if (hit_c && upd_take_c) begin
				mem_wr_en = 1'b1;
			end else if (!hit_c && done_c && count_q < DEPTH_C) begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = count_q[AW-1:0];
				mem_wr_data = new_entry_c;
			end
		end else if (state_q == S_SWEEP && pend_s1 && !drop_c) begin
			// Kept entries slide down; the write slot never passes the read slot.
			mem_wr_en   = 1'b1;
			mem_wr_addr = wr_q[AW-1:0];
			mem_wr_data = mem_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			next_cand_q <= RESERVED_RESET;
			pend_s1     <= 1'b0;
			rd_ptr_q    <= '0;
			wr_q        <= '0;
			rem_q       <= '0;
			cand_q      <= '0;
			start_q     <= '0;
			idx_s1      <= '0;
			req_q       <= '0;
			st_q        <= ST_NO_CHANGE;
			found_q     <= 1'b0;
			rdist_q     <= '0;
			rif_q       <= '0;
			newid_q     <= '0;
			out_q       <= '0;
		end else begin
			pend_s1 <= issue_c;
			idx_s1  <= rd_ptr_q[AW-1:0];
			if (emit_c) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q    <= req.data;
						st_q     <= first_st_c;
						found_q  <= 1'b0;
						rdist_q  <= '0;
						rif_q    <= '0;
						newid_q  <= '0;
						rd_ptr_q <= '0;
						wr_q     <= '0;
						rem_q    <= '0;
						case (req.data.command)
							CMD_UPDATE: begin
								if (req.data.node_addr == cfg.own_device_id) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_LOOKUP: state_q <= S_SCAN;
							CMD_AGE, CMD_IFDROP: state_q <= S_SWEEP;
							CMD_ALLOC: begin
								cand_q  <= start_c;
								start_q <= start_c;
								state_q <= S_SCAN;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end

				S_SCAN: begin
					if (hit_c) begin
						case (req_q.command)
							CMD_UPDATE: begin
								st_q    <= upd_take_c ? ST_OK : ST_NO_CHANGE;
								state_q <= S_EMIT;
							end
							CMD_ALLOC: begin
								// Candidate is taken: try the next one, or give up
								// once the search is back at its start.
								if (next_c == start_q) begin
									st_q    <= ST_NOT_FOUND;
									state_q <= S_EMIT;
								end else begin
									cand_q   <= next_c;
									rd_ptr_q <= '0;
								end
							end
							default: begin
								st_q    <= ST_OK;
								found_q <= 1'b1;
								rdist_q <= mem_rd_data.distance;
								rif_q   <= mem_rd_data.link_id;
								state_q <= S_EMIT;
							end
						endcase
					end else if (done_c) begin
						case (req_q.command)
							CMD_UPDATE: begin
								if (count_q >= DEPTH_C) begin
									st_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
									st_q    <= ST_OK;
								end
							end
							CMD_ALLOC: begin
								st_q        <= ST_OK;
								newid_q     <= cand_q;
								next_cand_q <= next_c;
							end
							default: st_q <= ST_NOT_FOUND;
						endcase
						state_q <= S_EMIT;
					end else if (issue_c) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
				end

				S_SWEEP: begin
					if (pend_s1) begin
						if (drop_c) begin
							rem_q <= rem_q + CW'(1);
						end else begin
							wr_q <= wr_q + CW'(1);
						end
					end
					if (done_c) begin
						count_q <= wr_q;
						st_q    <= ST_OK;
						state_q <= S_EMIT;
					end else if (issue_c) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
				end

				S_EMIT: begin
					if (emit_c) begin
						out_q   <= emit_data_c;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// Top level of the distance-vector route table: configuration registers,
// entry memory and sequencer. Depends on dvrt_pkg, dvrt_if, dvrt_mem, dvrt_ctrl.
//
//   channel   dir   handshake           payload
//   req       in    valid / ready       dvrt_pkg::req_t
//   rsp       out   valid / ready       dvrt_pkg::rsp_t
//   cfg       in    cfg_we              cfg_index, cfg_data
//
// Update, lookup, aging and interface removal issue at most one read per entry, wait out the
// read latency, then close the scan and post the result; sweeps compact through the single
// write port in the same pass. The sequencer returns to idle before it takes the next request.
// Allocation rescans the table per taken candidate. Reset empties the table at once.
// A new request is taken while the previous response waits; posting stalls until it leaves.
`timescale 1ns / 1ps

module distance_vector_route_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dvrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	dvrt_req_if.sink                            req,
	dvrt_rsp_if.source                          rsp
);
	import dvrt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	cfg_t    cfg_q;
	logic    wr_en;
	logic    rd_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	entry_t  wr_data;
	entry_t  rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{own_device_id: OWN_ID_RESET, reserved_id_count: RESERVED_RESET,
			           entry_timeout: TIMEOUT_RESET};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ID:   cfg_q.own_device_id     <= cfg_data[15:0];
				CFG_RESERVED: cfg_q.reserved_id_count <= cfg_data[15:0];
				CFG_TIMEOUT:  cfg_q.entry_timeout     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	dvrt_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dvrt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.req         (req),
		.rsp         (rsp),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

endmodule

// ===== sim/distance_vector_route_table_test.sv =====
// Self-checking regression for the distance-vector route table.
// Needs dvrt_pkg, the dvrt_req_if / dvrt_rsp_if channels and the table RTL;
// a route predictor with its own table copy, or a fixed row, sets each expected response.
`timescale 1ns / 1ps

module distance_vector_route_table_test;
	import dvrt_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int LIMIT_CYCLES = 6000000;
	localparam int REPLY_FIELDS = 7;

	// Command codes the block treats as no-ops.
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	typedef struct packed {
		logic typed;
		rsp_t want;
	} fixed_reply_t;

	typedef struct packed {
		req_t req_item;
		logic typed;
		rsp_t want;
	} opening_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dvrt_req_if req_ch ();
	dvrt_rsp_if rsp_ch ();

	distance_vector_route_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Route predictor state.
	entry_t route_tab [TABLE_DEPTH];
	int unsigned route_cnt = 0;
	logic [15:0] alloc_next = RESERVED_RESET;
	logic [15:0] cfg_own = OWN_ID_RESET;
	logic [15:0] cfg_reserved = RESERVED_RESET;
	logic [31:0] cfg_timeout = TIMEOUT_RESET;

	rsp_t route_reply_q[$];
	fixed_reply_t known_reply_q[$];
	opening_row_t opening_rows[$];

	string reply_field_name [REPLY_FIELDS] = '{"status", "found", "route_distance",
		"route_interface", "new_device_id", "removed_count", "entry_count"};

	int err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned reply_cnt = 0;
	int unsigned cmd_seen [8];
	int unsigned full_seen = 0;
	int unsigned exhausted_seen = 0;
	int unsigned removed_total = 0;

	// Stimulus shaping for the current phase.
	int send_gap_pct = 25;
	int rcv_gap_pct = 55;
	logic [15:0] pool_base = 16'd0;
	int unsigned pool_span = 48;
	logic [31:0] cur_time = 32'd0;
	int unsigned time_step = 1000;

	function automatic int find_route(logic [15:0] dev);
		for (int i = 0; i < route_cnt; i++)
			if (route_tab[i].device == dev)
				return i;
		return -1;
	endfunction

	// Drops matching routes and closes the gaps in order.
	function automatic int unsigned purge_routes(bit by_age, logic [31:0] now,
		logic [7:0] iface);
		int unsigned keep;
		int unsigned gone;
		logic [31:0] age;
		bit drop;
		keep = 0;
		gone = 0;
		for (int i = 0; i < route_cnt; i++) begin
			age = now - route_tab[i].seen_time;
			drop = by_age ? (age > cfg_timeout) : (route_tab[i].link_id == iface);
			if (drop) begin
				gone++;
			end else begin
				route_tab[keep] = route_tab[i];
				keep++;
			end
		end
		route_cnt = keep;
		return gone;
	endfunction

	function automatic int unsigned floor_id();
		return (cfg_reserved == 16'd0) ? 1 : int'(cfg_reserved);
	endfunction

	function automatic int unsigned step_id(int unsigned id);
		id++;
		if (id > 16'hFFFF)
			id = floor_id();
		return id;
	endfunction

	function automatic rsp_t predict_route(req_t r);
		rsp_t o;
		int idx;
		int unsigned start;
		int unsigned id;
		bit ok;
		o = '0;
		o.status = ST_NO_CHANGE;
		case (r.command)
			CMD_UPDATE: begin
				if (r.node_addr == cfg_own) begin
					o.status = ST_OWN_ID;
				end else begin
					idx = find_route(r.node_addr);
					if (idx < 0) begin
						if (route_cnt >= TABLE_DEPTH) begin
							o.status = ST_FULL;
						end else begin
							route_tab[route_cnt].device = r.node_addr;
							route_tab[route_cnt].distance = r.distance;
							route_tab[route_cnt].link_id = r.link_id;
							route_tab[route_cnt].seen_time = r.time_now;
							route_cnt++;
							o.status = ST_OK;
						end
					end else begin
						if (route_tab[idx].distance > r.distance) begin
							route_tab[idx].distance = r.distance;
							route_tab[idx].link_id = r.link_id;
						end
						if (route_tab[idx].distance == r.distance) begin
							route_tab[idx].seen_time = r.time_now;
							o.status = ST_OK;
						end
					end
				end
			end
			CMD_AGE: begin
				o.removed_count = 6'(purge_routes(1'b1, r.time_now, 8'd0));
				o.status = ST_OK;
			end
			CMD_IFDROP: begin
				o.removed_count = 6'(purge_routes(1'b0, 32'd0, r.link_id));
				o.status = ST_OK;
			end
			CMD_ALLOC: begin
				start = 32'(alloc_next);
				if (start < floor_id())
					start = floor_id();
				id = start;
				ok = 1'b1;
				// Walk candidates round-robin until one is free or the search comes back.
				while (ok && find_route(id[15:0]) >= 0) begin
					id = step_id(id);
					if (id == start)
						ok = 1'b0;
				end
				if (ok) begin
					o.new_device_id = id[15:0];
					alloc_next = 16'(step_id(id));
					o.status = ST_OK;
				end else begin
					o.status = ST_NOT_FOUND;
				end
			end
			CMD_LOOKUP: begin
				idx = find_route(r.node_addr);
				if (idx >= 0) begin
					o.found = 1'b1;
					o.route_distance = route_tab[idx].distance;
					o.route_interface = route_tab[idx].link_id;
					o.status = ST_OK;
				end else begin
					o.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		o.entry_count = 6'(route_cnt);
		return o;
	endfunction

	function automatic logic [15:0] reply_field(rsp_t r, int k);
		case (k)
			0: return 16'(r.status);
			1: return 16'(r.found);
			2: return 16'(r.route_distance);
			3: return 16'(r.route_interface);
			4: return r.new_device_id;
			5: return 16'(r.removed_count);
			default: return 16'(r.entry_count);
		endcase
	endfunction

	// Configuration, prediction and response checking, all on the rising edge.
	always @(posedge clk) begin : route_monitor
		rsp_t want_rsp;
		rsp_t pred_rsp;
		fixed_reply_t known;
		if (arst_n === 1'b1) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN_ID: cfg_own = cfg_data[15:0];
					CFG_RESERVED: cfg_reserved = cfg_data[15:0];
					CFG_TIMEOUT: cfg_timeout = cfg_data;
					default: begin
					end
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				reply_cnt++;
				if (route_reply_q.size() == 0) begin
					err_cnt++;
					$display("%0t ns: response with none expected, got %h", $time, rsp_ch.data);
				end else begin
					want_rsp = route_reply_q.pop_front();
					for (int k = 0; k < REPLY_FIELDS; k++) begin
						if (reply_field(rsp_ch.data, k) !== reply_field(want_rsp, k)) begin
							err_cnt++;
							$display("%0t ns: %s expected %0h got %0h", $time,
								reply_field_name[k], reply_field(want_rsp, k),
								reply_field(rsp_ch.data, k));
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				known = known_reply_q.pop_front();
				pred_rsp = predict_route(req_ch.data);
				cmd_seen[req_ch.data.command]++;
				if (pred_rsp.status == ST_FULL)
					full_seen++;
				if (req_ch.data.command == CMD_ALLOC && pred_rsp.status == ST_NOT_FOUND)
					exhausted_seen++;
				removed_total += 32'(pred_rsp.removed_count);
				route_reply_q.push_back(known.typed ? known.want : pred_rsp);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("distance_vector_route_table regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= rcv_gap_pct);
	end

	function automatic void add_row(logic [2:0] cmd, logic [15:0] dev, logic [7:0] iface,
		logic [7:0] hops, logic [31:0] now, logic typed, logic [2:0] st,
		logic [15:0] new_id, logic [5:0] cnt);
		opening_row_t row;
		row = '0;
		row.req_item.command = cmd;
		row.req_item.node_addr = dev;
		row.req_item.link_id = iface;
		row.req_item.distance = hops;
		row.req_item.time_now = now;
		row.typed = typed;
		row.want.status = st;
		row.want.new_device_id = new_id;
		row.want.entry_count = cnt;
		opening_rows.push_back(row);
	endfunction

	function automatic logic [15:0] random_device();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return 16'(pool_base + $urandom_range(pool_span - 1));
		else if (pick < 85)
			return cfg_own;
		return 16'($urandom);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			r.command = CMD_UPDATE;
		else if (pick < 55)
			r.command = CMD_AGE;
		else if (pick < 62)
			r.command = CMD_IFDROP;
		else if (pick < 77)
			r.command = CMD_ALLOC;
		else if (pick < 97)
			r.command = CMD_LOOKUP;
		else
			r.command = 3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
		r.node_addr = random_device();
		r.link_id = 8'(($urandom_range(99) < 80) ? $urandom_range(3) : $urandom);
		r.distance = 8'(($urandom_range(99) < 80) ? $urandom_range(7) : $urandom);
		if ($urandom_range(99) < 10) begin
			r.time_now = $urandom;
		end else begin
			cur_time = cur_time + $urandom_range(time_step);
			r.time_now = cur_time;
		end
		return r;
	endfunction

	task automatic send_request(req_t r, logic typed, rsp_t want);
		fixed_reply_t known;
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		known.typed = typed;
		known.want = want;
		known_reply_q.push_back(known);
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Holds off new requests until every outstanding response has been taken.
	task automatic drain_pipeline();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (route_reply_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(logic [15:0] own, logic [15:0] reserved, logic [31:0] timeout);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OWN_ID;
		cfg_data <= 32'(own);
		@(negedge clk);
		cfg_index <= CFG_RESERVED;
		cfg_data <= 32'(reserved);
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= timeout;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [15:0] own, logic [15:0] reserved, logic [31:0] timeout,
		logic [15:0] base, int unsigned span, logic [31:0] t0, int unsigned tstep,
		int n_items, int send_pct, int rcv_pct);
		drain_pipeline();
		configure(own, reserved, timeout);
		pool_base = base;
		pool_span = span;
		cur_time = t0;
		time_step = tstep;
		send_gap_pct = send_pct;
		rcv_gap_pct = rcv_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2 || $urandom_range(99) == 0)
				drain_pipeline();
			send_request(random_request(), 1'b0, '0);
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = CFG_OWN_ID;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		foreach (cmd_seen[k])
			cmd_seen[k] = 0;

		// Opening rows run on the reset configuration: own id 1, ids from 16, timeout 30000.
		add_row(CMD_LOOKUP, 16'd16, 8'd0, 8'd0, 32'd0, 1'b1, ST_NOT_FOUND, 16'd0, 6'd0);
		add_row(CMD_AGE, 16'd0, 8'd0, 8'd0, 32'd0, 1'b1, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd1, 8'd1, 8'd1, 32'd0, 1'b1, ST_OWN_ID, 16'd0, 6'd0);
		add_row(CMD_ALLOC, 16'd0, 8'd0, 8'd0, 32'd0, 1'b1, ST_OK, 16'd16, 6'd0);
		add_row(CMD_UPDATE, 16'h0000, 8'h00, 8'h00, 32'h0, 1'b1, ST_OK, 16'd0, 6'd1);
		add_row(CMD_UPDATE, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 16'd0, 6'd2);
		add_row(CMD_UPDATE, 16'd16, 8'd3, 8'd10, 32'd100, 1'b1, ST_OK, 16'd0, 6'd3);
		// Longer distance, then equal (refresh), then shorter (takes the new interface).
		add_row(CMD_UPDATE, 16'd16, 8'd4, 8'd12, 32'd200, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd16, 8'd5, 8'd10, 32'd300, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd16, 8'd6, 8'd7, 32'd400, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_LOOKUP, 16'd16, 8'd0, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_LOOKUP, 16'hFFFF, 8'd0, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_ALLOC, 16'd0, 8'd0, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_SPARE_A, 16'd16, 8'd6, 8'd0, 32'd0, 1'b1, ST_NO_CHANGE, 16'd0, 6'd3);
		add_row(CMD_SPARE_B, 16'd16, 8'd6, 8'd0, 32'd0, 1'b1, ST_NO_CHANGE, 16'd0, 6'd3);
		add_row(CMD_SPARE_C, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_NO_CHANGE,
			16'd0, 6'd3);
		// An age exactly equal to the timeout keeps the entry; one more unit drops it.
		add_row(CMD_AGE, 16'd0, 8'd0, 8'd0, 32'd30400, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_AGE, 16'd0, 8'd0, 8'd0, 32'd30401, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd2, 8'd9, 8'd1, 32'd30500, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd3, 8'd9, 8'd2, 32'd30500, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_UPDATE, 16'd4, 8'd8, 8'd3, 32'd30500, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_IFDROP, 16'd0, 8'd9, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_LOOKUP, 16'd4, 8'd0, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_IFDROP, 16'd0, 8'hFF, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);
		add_row(CMD_LOOKUP, 16'd2, 8'd0, 8'd0, 32'd0, 1'b0, ST_OK, 16'd0, 6'd0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i])
			send_request(opening_rows[i].req_item, opening_rows[i].typed, opening_rows[i].want);

		// The high-limit phase leaves the search start at 65535, so the zero-limit
		// phase that follows has to wrap past the top of the id space.
		run_phase(OWN_ID_RESET, RESERVED_RESET, TIMEOUT_RESET, 16'd0, 48, 32'd40000, 3000,
			280, 25, 55);
		run_phase(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd65500, 36, 32'h8000_0000,
			32'h0100_0000, 280, 25, 55);
		run_phase(16'h0000, 16'h0000, 32'h0000_0000, 16'd65530, 40, 32'h0000_1000, 1,
			280, 55, 25);
		run_phase(16'd65511, 16'd65520, 32'd20000, 16'd65520, 16, 32'hFFFF_F000, 200,
			280, 0, 0);

		drain_pipeline();
		repeat (64) @(negedge clk);

		$display("Checked %0d responses: %0d updates, %0d ages, %0d interface drops,",
			reply_cnt, cmd_seen[CMD_UPDATE], cmd_seen[CMD_AGE], cmd_seen[CMD_IFDROP]);
		$display("%0d allocations (%0d exhausted), %0d lookups, %0d full, %0d routes removed.",
			cmd_seen[CMD_ALLOC], exhausted_seen, cmd_seen[CMD_LOOKUP], full_seen,
			removed_total);
		if (err_cnt == 0)
			$display("distance_vector_route_table regression: pass");
		else
			$display("distance_vector_route_table regression: fail");
		$finish;
	end

endmodule
